// ===== rtl/core/lpl_pkg.sv =====
// lpl_pkg: shared constants, types and helpers of the look-ahead peak limiter.
// Depends on nothing; compiled first.
`default_nettype none

package lpl_pkg;

    localparam int SAMPLE_W      = 24;
    localparam int QUO_W         = 23;
    localparam int MUL_W         = SAMPLE_W + 1;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int FRAC_BITS     = 23;
    localparam int DELAY_LEN_DEF = 5;

    localparam logic [SAMPLE_W-1:0] ONE_Q23     = 24'd8388608;
    localparam logic [SAMPLE_W-1:0] ATTACK_Q23  = 24'd2516582;
    localparam logic [SAMPLE_W-1:0] RELEASE_Q23 = 24'd83886;

    typedef logic        [SAMPLE_W-1:0] level_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MUL_W-1:0]    mul_op_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PK_KEEP,
        S_PK_ADD,
        S_PK_SUM,
        S_TGT,
        S_DIV,
        S_GN_KEEP,
        S_GN_ADD,
        S_GN_SUM,
        S_OUT_MUL,
        S_OUT_LOAD
    } lpl_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Smoothing coefficient: attack when set, release otherwise.
    function automatic level_t coef(input logic att);
        return att ? ATTACK_Q23 : RELEASE_Q23;
    endfunction

    // Q1.23 product back to Q1.23 (floor); also valid for signed products.
    function automatic level_t q23_term(input prod_t p);
        return p[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lpl_if.sv =====
// Channel interfaces of the peak limiter: sample input, sample result, threshold write.
// Depends on lpl_pkg.
`default_nettype none

interface lpl_in_if;
    import lpl_pkg::*;
    logic    valid;
    logic    ready;
    sample_t sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface lpl_out_if;
    import lpl_pkg::*;
    logic    valid;
    logic    ready;
    sample_t sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface lpl_cfg_if;
    import lpl_pkg::*;
    logic   valid;
    logic   ready;
    level_t threshold;
    modport source (output valid, output threshold, input ready);
    modport sink   (input valid, input threshold, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lpl_mul.sv =====
// lpl_mul: shared signed multiplier with a registered product.
// Depends on lpl_pkg.
`default_nettype none

module lpl_mul (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire lpl_pkg::mul_op_t op_a,
    input  wire lpl_pkg::mul_op_t op_b,
    output      lpl_pkg::prod_t   prod
);
    import lpl_pkg::*;

    prod_t prod_reg;

    // Hold the product until the next issue.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lpl_div.sv =====
// lpl_div: radix-2 restoring divider, (num << 23) / den with num < den, one bit a cycle.
// Depends on lpl_pkg.
`default_nettype none

module lpl_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire lpl_pkg::level_t  num,
    input  wire lpl_pkg::level_t  den,
    output      lpl_pkg::level_t  quo,
    output      lpl_pkg::div_stat_t stat
);
    import lpl_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic [SAMPLE_W:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [SAMPLE_W:0]  shifted;
    logic [SAMPLE_W:0]  diff;
    logic               fits;

    always_comb
    begin
        shifted   = {rem_reg[SAMPLE_W-1:0], 1'b0};
        diff      = shifted - {1'b0, den};
        fits      = (shifted >= {1'b0, den});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, num};
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Subtract when the divisor fits, shift in the quotient bit.
            rem_next = fits ? diff : shifted;
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quo       = {{(SAMPLE_W - QUO_W){1'b0}}, quo_reg};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lpl_delay.sv =====
// lpl_delay: look-ahead sample ring, read-before-write at one pointer, zero until written.
// Depends on lpl_pkg.
`default_nettype none

module lpl_delay #(
    parameter int DEPTH = lpl_pkg::DELAY_LEN_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire lpl_pkg::sample_t wr_data,
    output      lpl_pkg::sample_t rd_data
);
    import lpl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sample_t            mem_reg [DEPTH];
    sample_t            rd_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;

    always_comb
    begin
        if (ptr_reg == PTR_W'(DEPTH - 1))
        begin
            ptr_next = '0;
        end
        else
        begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[ptr_reg] <= 1'b1;
            ptr_reg            <= ptr_next;
        end
    end

    // Read the oldest sample, then overwrite it with the new one.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rd_reg           <= valid_reg[ptr_reg] ? mem_reg[ptr_reg] : '0;
            mem_reg[ptr_reg] <= wr_data;
        end
    end

    assign rd_data = rd_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lookahead_peak_limiter_unit.sv =====
// lookahead_peak_limiter_unit: top level of the look-ahead peak limiter.
// Depends on lpl_pkg, lpl_if, lpl_mul, lpl_div and lpl_delay.
//
//   channel   modport     payload                  meaning
//   audio     lpl_in_if   sample_in  s24 Q1.23     one request per audio sample
//   limited   lpl_out_if  sample_out s24 Q1.23     one result per sample
//   cfg       lpl_cfg_if  threshold  u24 Q1.23     limit level, held to 1.0
//
// Flow: the divider is skipped when the peak is at or below the threshold, and
// the target gain waits on the 23-step divider otherwise; the single shared
// multiplier and the bit-serial divider set the pace.
// Reset: threshold 1.0, peak 0, gain 1.0, delay ring reads zero until written.
// Stalls: a finished result waits in the output register while the next request
// is taken; a sample completes only once that register is free.
`default_nettype none

module lookahead_peak_limiter_unit #(
    parameter int DELAY_LEN = lpl_pkg::DELAY_LEN_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    lpl_in_if.sink     audio,
    lpl_out_if.source  limited,
    lpl_cfg_if.sink    cfg
);
    import lpl_pkg::*;

    lpl_state_t state_reg, state_next;
    level_t     a_reg, a_next;
    level_t     peak_reg, peak_next;
    level_t     gain_reg, gain_next;
    level_t     thr_reg, thr_next;
    level_t     f_reg, f_next;
    level_t     acc_reg, acc_next;
    logic       att_reg, att_next;
    logic       out_valid_reg, out_valid_next;
    sample_t    out_data_reg, out_data_next;

    logic       accept;
    logic       mul_en;
    mul_op_t    mul_a, mul_b;
    prod_t      prod;
    level_t     term;
    logic       div_start;
    level_t     div_quo;
    div_stat_t  div_st;
    sample_t    delayed;

    assign accept = audio.valid && audio.ready;
    assign term   = q23_term(prod);

    lpl_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    lpl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (thr_reg),
        .den   (peak_reg),
        .quo   (div_quo),
        .stat  (div_st)
    );

    lpl_delay #(
        .DEPTH (DELAY_LEN)
    ) u_delay (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (audio.sample_in),
        .rd_data (delayed)
    );

    // Sequencer: peak smoothing, target gain, gain smoothing, output scale.
    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        peak_next      = peak_reg;
        gain_next      = gain_reg;
        f_next         = f_reg;
        acc_next       = acc_reg;
        att_next       = att_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !limited.ready;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Magnitude; negative full scale maps to exactly 1.0.
                    a_next     = audio.sample_in[SAMPLE_W-1]
                                 ? level_t'(-audio.sample_in)
                                 : level_t'(audio.sample_in);
                    state_next = S_PK_KEEP;
                end
            end
            S_PK_KEEP:
            begin
                att_next   = (a_reg > peak_reg);
                mul_en     = 1'b1;
                mul_a      = mul_op_t'({1'b0, ONE_Q23 - coef(att_next)});
                mul_b      = mul_op_t'({1'b0, peak_reg});
                state_next = S_PK_ADD;
            end
            S_PK_ADD:
            begin
                acc_next   = term;
                mul_en     = 1'b1;
                mul_a      = mul_op_t'({1'b0, coef(att_reg)});
                mul_b      = mul_op_t'({1'b0, a_reg});
                state_next = S_PK_SUM;
            end
            S_PK_SUM:
            begin
                peak_next  = acc_reg + term;
                state_next = S_TGT;
            end
            S_TGT:
            begin
                // Skip the divide when the peak is zero or within the limit.
                if (peak_reg == '0 || peak_reg <= thr_reg)
                begin
                    f_next     = ONE_Q23;
                    state_next = S_GN_KEEP;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    f_next     = div_quo;
                    state_next = S_GN_KEEP;
                end
            end
            S_GN_KEEP:
            begin
                att_next   = (f_reg < gain_reg);
                mul_en     = 1'b1;
                mul_a      = mul_op_t'({1'b0, ONE_Q23 - coef(att_next)});
                mul_b      = mul_op_t'({1'b0, gain_reg});
                state_next = S_GN_ADD;
            end
            S_GN_ADD:
            begin
                acc_next   = term;
                mul_en     = 1'b1;
                mul_a      = mul_op_t'({1'b0, coef(att_reg)});
                mul_b      = mul_op_t'({1'b0, f_reg});
                state_next = S_GN_SUM;
            end
            S_GN_SUM:
            begin
                gain_next  = acc_reg + term;
                state_next = S_OUT_MUL;
            end
            S_OUT_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = mul_op_t'({1'b0, gain_reg});
                mul_b      = mul_op_t'({delayed[SAMPLE_W-1], delayed});
                state_next = S_OUT_LOAD;
            end
            S_OUT_LOAD:
            begin
                // Hold until the output register is free; the shift floors.
                if (!out_valid_reg || limited.ready)
                begin
                    out_data_next  = sample_t'(term);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Threshold write; clamp anything above unity.
    always_comb
    begin
        thr_next = thr_reg;
        if (cfg.valid && cfg.ready)
        begin
            thr_next = (cfg.threshold > ONE_Q23) ? ONE_Q23 : cfg.threshold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            peak_reg      <= '0;
            gain_reg      <= ONE_Q23;
            thr_reg       <= ONE_Q23;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            gain_reg      <= gain_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        f_reg        <= f_next;
        acc_reg      <= acc_next;
        att_reg      <= att_next;
        out_data_reg <= out_data_next;
    end

    assign audio.ready       = (state_reg == S_IDLE);
    assign cfg.ready         = 1'b1;
    assign limited.valid     = out_valid_reg;
    assign limited.sample_out = out_data_reg;

    // The divider only runs while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_st.busy |-> (state_reg == S_DIV))
        else $error("divider busy outside the divide step");

    // An accepted request always starts the peak update.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_PK_KEEP))
        else $error("accepted request did not start processing");

    // Smoothed peak and gain never exceed unity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (peak_reg <= ONE_Q23) && (gain_reg <= ONE_Q23))
        else $error("peak or gain above unity");

    // The stored threshold stays within range.
    assert property (@(posedge clk) disable iff (!rst_n)
        thr_reg <= ONE_Q23)
        else $error("threshold above unity");

    // A divide result lands exactly when the divider finishes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_st.done) |=> (state_reg == S_GN_KEEP))
        else $error("divide result not consumed");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for lookahead_peak_limiter_unit.
// Sends samples and threshold writes over the lpl_if channels and checks each result
// against a fixed-point predictor or a typed-in value. Depends on lpl_pkg and lpl_if.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lpl_pkg::*;

    localparam int DLY         = DELAY_LEN_DEF;
    localparam int PHASES      = 8;
    localparam int PHASE_LEN   = 160;
    localparam int MAX_REPORTS = 10;
    localparam int PLAN_LEN    = 24;

    // Directed rows: a threshold write, a sample checked by the predictor, or a
    // sample whose result is typed in below.
    typedef enum logic [1:0] {
        ROW_THRESHOLD,
        ROW_SAMPLE,
        ROW_SAMPLE_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [SAMPLE_W-1:0] value;
        sample_t             want;
    } row_t;

    // With the threshold at unity the gain never leaves unity, so the first
    // rows come out as the input delayed by DLY requests, exactly.
    row_t plan [PLAN_LEN] = '{
        '{ROW_SAMPLE_TYPED, 24'h000000, 24'h000000},  // delay ring reads zero after reset
        '{ROW_SAMPLE_TYPED, 24'h7FFFFF, 24'h000000},
        '{ROW_SAMPLE_TYPED, 24'h800000, 24'h000000},
        '{ROW_SAMPLE_TYPED, 24'hFFFFFF, 24'h000000},
        '{ROW_SAMPLE_TYPED, 24'h000001, 24'h000000},
        '{ROW_SAMPLE_TYPED, 24'h400000, 24'h000000},
        '{ROW_SAMPLE_TYPED, 24'hC00000, 24'h7FFFFF},  // positive full scale comes back
        '{ROW_SAMPLE_TYPED, 24'h7FFFFF, 24'h800000},  // negative full scale kept exactly
        '{ROW_SAMPLE_TYPED, 24'h800000, 24'hFFFFFF},  // -1 stays -1 at unity gain
        '{ROW_SAMPLE_TYPED, 24'h000000, 24'h000001},
        '{ROW_SAMPLE_TYPED, 24'h000000, 24'h400000},
        '{ROW_THRESHOLD,    24'h000000, 24'h000000},  // zero threshold: target gain zero
        '{ROW_SAMPLE,       24'h800000, 24'h000000},
        '{ROW_SAMPLE,       24'h7FFFFF, 24'h000000},
        '{ROW_SAMPLE,       24'h000000, 24'h000000},
        '{ROW_SAMPLE,       24'h000000, 24'h000000},
        '{ROW_THRESHOLD,    24'hFFFFFF, 24'h000000},  // above unity: held to unity
        '{ROW_SAMPLE,       24'h7FFFFF, 24'h000000},
        '{ROW_SAMPLE,       24'h000000, 24'h000000},
        '{ROW_THRESHOLD,    24'h200000, 24'h000000},  // quarter scale: divider path
        '{ROW_SAMPLE,       24'h7FFFFF, 24'h000000},
        '{ROW_SAMPLE,       24'h800000, 24'h000000},
        '{ROW_SAMPLE,       24'h7FFFFF, 24'h000000},
        '{ROW_SAMPLE,       24'h000064, 24'h000000}   // negative products floor downward
    };

    logic clk = 1'b0;
    logic rst_n;

    lpl_in_if  audio_ch ();
    lpl_out_if limited_ch ();
    lpl_cfg_if cfg_ch ();

    lookahead_peak_limiter_unit #(
        .DELAY_LEN (DLY)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .audio   (audio_ch.sink),
        .limited (limited_ch.source),
        .cfg     (cfg_ch.sink)
    );

    always #6 clk = ~clk;

    // Predictor state: threshold, peak follower, smoothed gain, delay ring.
    level_t      lim_threshold;
    level_t      lim_peak;
    level_t      lim_gain;
    sample_t     lim_ring [DLY];
    int unsigned lim_pos;

    // Results still owed by the block, oldest first.
    sample_t pending_out [$];
    int      bad_count = 0;

    // Sender burst bookkeeping and the state of the synthetic program material.
    int unsigned         burst_left = 0;
    int unsigned         seg_left = 0;
    int unsigned         seg_mode = 0;
    logic [SAMPLE_W-1:0] seg_amp = 24'h100000;
    bit                  seg_sign = 1'b0;

    // One-pole step: keep (1-rate) of the old value, add rate of the goal; each
    // product floors on its own before the sum.
    function automatic level_t glide(input level_t prev, input level_t goal, input level_t rate);
        logic [63:0] keep;
        logic [63:0] add;
        keep = ((64'(ONE_Q23) - 64'(rate)) * 64'(prev)) >> FRAC_BITS;
        add  = (64'(rate) * 64'(goal)) >> FRAC_BITS;
        return level_t'(keep + add);
    endfunction

    // Advance the limiter model by one sample and return the delayed, scaled output.
    function sample_t limit_predict(input sample_t x);
        level_t              mag;
        level_t              rate;
        level_t              goal;
        logic signed [63:0]  g64;
        logic signed [63:0]  d64;
        logic signed [63:0]  prod;
        sample_t             y;
        mag  = x[SAMPLE_W-1] ? (~x + 1'b1) : x;
        rate = (mag > lim_peak) ? ATTACK_Q23 : RELEASE_Q23;
        lim_peak = glide(lim_peak, mag, rate);
        if (lim_peak == '0 || lim_peak <= lim_threshold)
            goal = ONE_Q23;
        else
            goal = level_t'(({40'b0, lim_threshold} << FRAC_BITS) / {40'b0, lim_peak});
        rate = (goal < lim_gain) ? ATTACK_Q23 : RELEASE_Q23;
        lim_gain = glide(lim_gain, goal, rate);
        g64  = {40'b0, lim_gain};
        d64  = lim_ring[lim_pos];
        prod = g64 * d64;
        y    = sample_t'(prod >>> FRAC_BITS);
        lim_ring[lim_pos] = x;
        lim_pos = (lim_pos == DLY - 1) ? 0 : lim_pos + 1;
        return y;
    endfunction

    // Synthetic audio in segments: loud passages, quiet ones, noise, silence and
    // square waves, so the gain is pulled down and then released.
    function sample_t music_sample();
        sample_t             s;
        logic [SAMPLE_W-1:0] m;
        int unsigned         r;
        if (seg_left == 0)
        begin
            seg_left = $urandom_range(4, 48);
            seg_mode = $urandom_range(0, 4);
            seg_amp  = SAMPLE_W'($urandom_range(1, 24'h7FFFFF));
        end
        seg_left--;
        case (seg_mode)
            0:
            begin
                r = $urandom_range(0, 7);
                if (r == 0)
                    s = 24'h7FFFFF;
                else if (r == 1)
                    s = 24'h800000;
                else
                begin
                    m = SAMPLE_W'($urandom_range(24'h600000, 24'h7FFFFF));
                    s = $urandom_range(0, 1) ? m : -m;
                end
            end
            1:
            begin
                m = SAMPLE_W'($urandom_range(0, 4095));
                s = $urandom_range(0, 1) ? m : -m;
            end
            2: s = sample_t'($urandom);
            3: s = '0;
            default:
            begin
                seg_sign = ~seg_sign;
                s = seg_sign ? seg_amp : -seg_amp;
            end
        endcase
        return s;
    endfunction

    // Offer one sample request; open a new burst after a random gap when the last
    // one is used up. Record the expectation once the request is taken.
    task automatic send_sample(input sample_t x, input bit typed, input sample_t want);
        int unsigned gap;
        sample_t     guess;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                audio_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        end
        audio_ch.valid     <= 1'b1;
        audio_ch.sample_in <= x;
        do @(posedge clk); while (!audio_ch.ready);
        burst_left--;
        guess = limit_predict(x);
        pending_out.push_back(typed ? want : guess);
    endtask

    // Drop the sample valid and hold until every owed result is back.
    task automatic drain_block();
        audio_ch.valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write the threshold on an idle block; the block holds values above unity to unity.
    task automatic write_threshold(input level_t v);
        drain_block();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.threshold <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid  <= 1'b0;
        lim_threshold = (v > ONE_Q23) ? ONE_Q23 : v;
    endtask

    // Result side: stall on a rotating pattern that is redrawn at the end of each random
    // run; one of the patterns never stalls.
    initial
    begin : out_stall
        logic [31:0] stall_word;
        int unsigned mode_left;
        limited_ch.ready = 1'b0;
        stall_word = '1;
        mode_left  = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(64, 400);
                case ($urandom_range(0, 3))
                    0:       stall_word = '1;
                    1:       stall_word = $urandom;
                    2:       stall_word = $urandom & $urandom;
                    default: stall_word = $urandom | $urandom;
                endcase
                if (stall_word == '0)
                    stall_word = 32'h1;
            end
            mode_left--;
            limited_ch.ready <= stall_word[0];
            stall_word = {stall_word[0], stall_word[31:1]};
        end
    end

    // Compare every taken result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        sample_t want;
        if (rst_n && limited_ch.valid && limited_ch.ready)
        begin
            if (pending_out.size() == 0)
            begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("unexpected result %0d with nothing owed", limited_ch.sample_out);
            end
            else
            begin
                want = pending_out.pop_front();
                if (limited_ch.sample_out !== want)
                begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS)
                        $display("sample_out mismatch: expected %0d, got %0d",
                                 want, limited_ch.sample_out);
                end
            end
        end
    end

    initial
    begin : stimulus
        int          wait_cycles;
        level_t      thr;
        rst_n              = 1'b0;
        audio_ch.valid     = 1'b0;
        audio_ch.sample_in = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.threshold   = '0;

        // Model reset state matches the block: unity threshold and gain.
        lim_threshold = ONE_Q23;
        lim_peak      = '0;
        lim_gain      = ONE_Q23;
        lim_pos       = 0;
        for (int i = 0; i < DLY; i++)
            lim_ring[i] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            case (plan[i].kind)
                ROW_THRESHOLD:    write_threshold(plan[i].value);
                ROW_SAMPLE:       send_sample(plan[i].value, 1'b0, '0);
                ROW_SAMPLE_TYPED: send_sample(plan[i].value, 1'b1, plan[i].want);
                default:          ;
            endcase
        end

        // Random phases, each under its own threshold, the extremes among them.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       thr = '0;
                1:       thr = 24'hFFFFFF;
                2:       thr = level_t'($urandom);
                3:       thr = level_t'($urandom_range(ONE_Q23 / 8, ONE_Q23 / 2));
                4:       thr = ONE_Q23;
                5:       thr = level_t'($urandom_range(1, 24'h000FFF));
                default: thr = level_t'($urandom_range(0, ONE_Q23));
            endcase
            write_threshold(thr);
            for (int k = 0; k < PHASE_LEN; k++)
                send_sample(music_sample(), 1'b0, '0);
        end

        // Wait out the owed results, then keep watching for strays.
        audio_ch.valid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 4000 && pending_out.size() != 0; wait_cycles++)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (pending_out.size() != 0)
        begin
            bad_count += pending_out.size();
            $display("%0d results never arrived", pending_out.size());
        end

        if (bad_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: ends the run with TB_ERROR if the stimulus never finishes.
    initial
    begin : watchdog
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
